### design/stwp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stwp_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_STAGES    = 6;
  localparam int MIX_STAGES     = 4;
  localparam int N_STAGES       = TRIG_STAGES + MIX_STAGES;
  localparam int UV_W           = 17;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 96;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 48;

  localparam logic [31:0] POLY_C1 = 32'd1686629713;
  localparam logic [31:0] POLY_C3 = 32'd693598668;
  localparam logic [31:0] POLY_C5 = 32'd85569306;
  localparam logic [31:0] POLY_C7 = 32'd4858527;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_RADIUS = 3'd1,
    REG_BASE   = 3'd2,
    REG_ROT_X  = 3'd3,
    REG_ROT_Y  = 3'd4,
    REG_AXIS   = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    SURF_CYLINDER = 1'b0,
    SURF_SPHERE   = 1'b1
  } surf_mode_t;

  typedef struct packed {
    surf_mode_t  mode;
    logic [15:0] radius;
    logic [47:0] base;
    logic [47:0] rot_x;
    logic [47:0] rot_y;
    logic [47:0] axis;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } trig_t;

  function automatic logic signed [15:0] sat_pt(input logic signed [21:0] x);
    logic signed [15:0] r;
    if (x > 22'sd32767) r = 16'sh7fff;
    else if (x < -22'sd32768) r = -16'sd32768;
    else r = x[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat_nm(input logic signed [17:0] x);
    logic signed [15:0] r;
    if (x > 18'sd16384) r = 16'sd16384;
    else if (x < -18'sd16384) r = -16'sd16384;
    else r = x[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### design/stwp_trig.sv
`timescale 1ns / 1ps
`default_nettype none
module stwp_trig #(
  parameter int ANGLE_BITS = stwp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic [stwp_pkg::TRIG_STAGES-1:0]     en,
  input  wire logic [31:0]                          phase,
  output stwp_pkg::trig_t                           result
);
  import stwp_pkg::*;

  localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic [31:0] ph_m;
  assign ph_m = phase & KEEP;

  // [0] = r path (sine-like), [1] = one minus r path
  logic [1:0]       q_r  [1:5];
  logic [1:0][30:0] x_r  [1:5];
  logic [1:0][30:0] x2_r [2:4];
  logic [1:0][31:0] p_r  [3:5];
  trig_t            res_r;

  logic [1:0][61:0] sq;
  logic [1:0][62:0] m3, m4, m5, m6;
  logic [31:0]      qa, qb;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sq[k] = 62'(x_r[1][k]) * 62'(x_r[1][k]);
      m3[k] = 63'(POLY_C7) * 63'(x2_r[2][k]);
      m4[k] = 63'(p_r[3][k]) * 63'(x2_r[3][k]);
      m5[k] = 63'(p_r[4][k]) * 63'(x2_r[4][k]);
      m6[k] = 63'(p_r[5][k]) * 63'(x_r[5][k]);
    end
    qa = m6[0][61:30];
    qb = m6[1][61:30];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_r[1]    <= ph_m[31:30];
      x_r[1][0] <= {1'b0, ph_m[29:0]};
      x_r[1][1] <= Q30_ONE - {1'b0, ph_m[29:0]};
    end
    if (en[1]) begin
      q_r[2] <= q_r[1];
      x_r[2] <= x_r[1];
      for (int k = 0; k < 2; k++) x2_r[2][k] <= sq[k][60:30];
    end
    if (en[2]) begin
      q_r[3]  <= q_r[2];
      x_r[3]  <= x_r[2];
      x2_r[3] <= x2_r[2];
      for (int k = 0; k < 2; k++) p_r[3][k] <= POLY_C5 - m3[k][61:30];
    end
    if (en[3]) begin
      q_r[4]  <= q_r[3];
      x_r[4]  <= x_r[3];
      x2_r[4] <= x2_r[3];
      for (int k = 0; k < 2; k++) p_r[4][k] <= POLY_C3 - m4[k][61:30];
    end
    if (en[4]) begin
      q_r[5]  <= q_r[4];
      x_r[5]  <= x_r[4];
      for (int k = 0; k < 2; k++) p_r[5][k] <= POLY_C1 - m5[k][61:30];
    end
    if (en[5]) begin
      case (q_r[5])
        2'd0: begin
          res_r.sn <= $signed(qa);
          res_r.cs <= $signed(qb);
        end
        2'd1: begin
          res_r.sn <= $signed(qb);
          res_r.cs <= -$signed(qa);
        end
        2'd2: begin
          res_r.sn <= -$signed(qa);
          res_r.cs <= -$signed(qb);
        end
        default: begin
          res_r.sn <= -$signed(qb);
          res_r.cs <= $signed(qa);
        end
      endcase
    end
  end

  assign result = res_r;

endmodule
`default_nettype wire

### design/stwp_mix.sv
`timescale 1ns / 1ps
`default_nettype none
module stwp_mix (
  input  wire logic                                clk,
  input  wire logic [stwp_pkg::MIX_STAGES-1:0]     en,
  input  stwp_pkg::cfg_t                           cfg,
  input  stwp_pkg::trig_t                          ta,
  input  stwp_pkg::trig_t                          tb,
  input  wire logic [stwp_pkg::UV_W-1:0]           v_in,
  output logic [stwp_pkg::OUT_DATA_W-1:0]          data_out
);
  import stwp_pkg::*;

  localparam logic signed [48:0] HALF16 = 49'sd32768;
  localparam logic signed [63:0] HALF30W = 64'sd1 <<< 29;
  localparam logic signed [49:0] HALF28 = 50'sd1 <<< 27;
  localparam logic signed [49:0] HALF30 = 50'sd1 <<< 29;
  localparam logic signed [31:0] HALF16S = 32'sd32768;

  logic signed [16:0] r_s;
  assign r_s = $signed({1'b0, cfg.radius});

  // stage 7
  logic signed [48:0] plx, ply;
  logic signed [63:0] pcx, pcy;
  logic signed [31:0] lx_r, ly_r, cx_r, cy_r, c7_r, s7_r, se7_r;
  logic [UV_W-1:0]    v7_r;

  always_comb begin
    plx = r_s * (-ta.cs);
    ply = r_s * (-ta.sn);
    pcx = ta.cs * tb.cs;
    pcy = ta.sn * tb.cs;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lx_r  <= 32'((plx + HALF16) >>> 16);
      ly_r  <= 32'((ply + HALF16) >>> 16);
      cx_r  <= 32'((pcx + HALF30W) >>> 30);
      cy_r  <= 32'((pcy + HALF30W) >>> 30);
      c7_r  <= ta.cs;
      s7_r  <= ta.sn;
      se7_r <= tb.sn;
      v7_r  <= v_in;
    end
  end

  // stage 8
  logic signed [48:0] t1_nxt [3];
  logic signed [47:0] t2_nxt [3], n1_nxt [3], n2_nxt [3];
  logic signed [33:0] t3_nxt [3];
  logic signed [17:0] ns_nxt [3];
  logic signed [15:0] rx [3], ry [3], ax [3];
  logic signed [31:0] sph_c [3];
  logic signed [17:0] v_s;

  logic signed [48:0] t1_r [3];
  logic signed [47:0] t2_r [3], n1_r [3], n2_r [3];
  logic signed [33:0] t3_r [3];
  logic signed [17:0] ns_r [3];

  always_comb begin
    v_s = $signed({1'b0, v7_r});
    sph_c[0] = cx_r;
    sph_c[1] = cy_r;
    sph_c[2] = se7_r;
    for (int j = 0; j < 3; j++) begin
      rx[j] = $signed(cfg.rot_x[16*j +: 16]);
      ry[j] = $signed(cfg.rot_y[16*j +: 16]);
      ax[j] = $signed(cfg.axis[16*j +: 16]);
      if (cfg.mode == SURF_SPHERE) t1_nxt[j] = r_s * sph_c[j];
      else t1_nxt[j] = lx_r * rx[j];
      t2_nxt[j] = ly_r * ry[j];
      t3_nxt[j] = v_s * ax[j];
      n1_nxt[j] = c7_r * rx[j];
      n2_nxt[j] = s7_r * ry[j];
      ns_nxt[j] = 18'((sph_c[j] + HALF16S) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 3; j++) begin
        t1_r[j] <= t1_nxt[j];
        t2_r[j] <= t2_nxt[j];
        t3_r[j] <= t3_nxt[j];
        n1_r[j] <= n1_nxt[j];
        n2_r[j] <= n2_nxt[j];
        ns_r[j] <= ns_nxt[j];
      end
    end
  end

  // stage 9
  logic signed [49:0] e1, e2, e3, e4, acc, nacc;
  logic signed [21:0] pt_nxt [3];
  logic signed [17:0] nm_nxt [3];
  logic signed [21:0] pt_r [3];
  logic signed [17:0] nm_r [3];
  logic signed [15:0] bs9 [3];

  always_comb begin
    e1 = '0; e2 = '0; e3 = '0; e4 = '0; acc = '0; nacc = '0;
    for (int j = 0; j < 3; j++) begin
      bs9[j] = $signed(cfg.base[16*j +: 16]);
      e1 = t1_r[j];
      e2 = t2_r[j];
      e3 = t3_r[j];
      e4 = bs9[j];
      if (cfg.mode == SURF_SPHERE) begin
        pt_nxt[j] = 22'((e1 + HALF30) >>> 30);
        nm_nxt[j] = ns_r[j];
      end else begin
        acc = e1 + e2 + (e3 <<< 12) + (e4 <<< 28);
        pt_nxt[j] = 22'((acc + HALF28) >>> 28);
        e1 = n1_r[j];
        e2 = n2_r[j];
        nacc = e1 + e2 + HALF30;
        nm_nxt[j] = 18'(nacc >>> 30);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        pt_r[j] <= pt_nxt[j];
        nm_r[j] <= nm_nxt[j];
      end
    end
  end

  // stage 10: output register
  logic [OUT_DATA_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        out_r[16*j +: 16]     <= sat_pt(pt_r[j]);
        out_r[48 + 16*j +: 16] <= sat_nm(nm_r[j]);
      end
    end
  end

  assign data_out = out_r;

endmodule
`default_nettype wire

### design/surface_texcoord_to_world_point.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle unless out_tready stalls the output; the
// polynomial sine/cosine chain takes six register stages, and the
// rotate/scale/accumulate path four more.
// Stages advance independently, so bubbles are squeezed out under backpressure.
// Reset (rst_n low, synchronous) clears all stage valids and loads register defaults.
module surface_texcoord_to_world_point #(
  parameter int ANGLE_BITS = stwp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [stwp_pkg::IN_DATA_W-1:0]    in_tdata,   // u_frac[16:0], v_frac[33:17]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [stwp_pkg::OUT_DATA_W-1:0]        out_tdata,  // point_x, point_y, point_z,
                                                             // normal_x, normal_y, normal_z
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [stwp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stwp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stwp_pkg::*;

  // configuration registers
  surf_mode_t  mode_r;
  logic [15:0] radius_r;
  logic [47:0] base_r, rot_x_r, rot_y_r, axis_r;
  cfg_t        cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= SURF_CYLINDER;
      radius_r <= 16'd256;
      base_r   <= 48'd0;
      rot_x_r  <= 48'd16384;
      rot_y_r  <= 48'd1073741824;
      axis_r   <= 48'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:   mode_r   <= surf_mode_t'(cfg_data[0]);
        REG_RADIUS: radius_r <= cfg_data[15:0];
        REG_BASE:   base_r   <= cfg_data;
        REG_ROT_X:  rot_x_r  <= cfg_data;
        REG_ROT_Y:  rot_y_r  <= cfg_data;
        REG_AXIS:   axis_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = '{mode: mode_r, radius: radius_r, base: base_r,
                 rot_x: rot_x_r, rot_y: rot_y_r, axis: axis_r};

  // stage valids and per-stage enables
  logic [N_STAGES:1] vld_r;
  logic [N_STAGES:1] en;

  assign en[N_STAGES] = !vld_r[N_STAGES] || out_tready;
  for (genvar k = 1; k < N_STAGES; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_tvalid;
      for (int k = 2; k <= N_STAGES; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = vld_r[N_STAGES];

  // phases
  logic [UV_W-1:0] u_in, v_in;
  logic [31:0]     uph, eph;

  assign u_in = in_tdata[UV_W-1:0];
  assign v_in = in_tdata[2*UV_W-1:UV_W];
  assign uph  = {u_in[15:0], 16'd0};
  assign eph  = {v_in, 15'd0} + 32'hC000_0000;

  trig_t ta, tb;

  stwp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_a (
    .clk    (clk),
    .en     (en[TRIG_STAGES:1]),
    .phase  (uph),
    .result (ta)
  );

  stwp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_b (
    .clk    (clk),
    .en     (en[TRIG_STAGES:1]),
    .phase  (eph),
    .result (tb)
  );

  // v follows the trig pipeline
  logic [UV_W-1:0] v_d_r [1:TRIG_STAGES];

  always_ff @(posedge clk) begin
    if (en[1]) v_d_r[1] <= v_in;
    for (int k = 2; k <= TRIG_STAGES; k++) begin
      if (en[k]) v_d_r[k] <= v_d_r[k-1];
    end
  end

  stwp_mix u_mix (
    .clk      (clk),
    .en       (en[N_STAGES:TRIG_STAGES+1]),
    .cfg      (cfg),
    .ta       (ta),
    .tb       (tb),
    .v_in     (v_d_r[TRIG_STAGES]),
    .data_out (out_tdata)
  );

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_drain_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !vld_r[N_STAGES-1] |=> !out_tvalid)
    else $error("result repeated after drain");

endmodule
`default_nettype wire

### tb/tb_surface_texcoord_to_world_point.sv
`timescale 1ns / 1ps
module tb_surface_texcoord_to_world_point;
  import stwp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int LATENCY = N_STAGES;

  class surface_point_scoreboard;
    bit          mode;
    bit [15:0]   radius;
    bit [47:0]   base, rot_x, rot_y, axis;
    bit [95:0]   expected_points[$];

    function new();
      mode = SURF_CYLINDER; radius = 16'd256; base = '0;
      rot_x = 48'd16384; rot_y = 48'd1073741824; axis = 48'd256;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
      case (idx)
        REG_MODE:   mode = val[0];
        REG_RADIUS: radius = val[15:0];
        REG_BASE:   base = val;
        REG_ROT_X:  rot_x = val;
        REG_ROT_Y:  rot_y = val;
        REG_AXIS:   axis = val;
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int s);
      longint bias, t;
      bias = 64'sd1 <<< 62;
      t = v + bias + (64'sd1 <<< (s - 1));
      return (t >>> s) - (bias >>> s);
    endfunction

    function longint lane(bit [47:0] p, int k);
      return longint'($signed(p[16*k +: 16]));
    endfunction

    function longint quarter_sine(longint unsigned x);
      longint unsigned x2, p;
      x2 = (x * x) >> 30;
      p = POLY_C7;
      p = POLY_C5 - ((p * x2) >> 30);
      p = POLY_C3 - ((p * x2) >> 30);
      p = POLY_C1 - ((p * x2) >> 30);
      return longint'((p * x) >> 30);
    endfunction

    function void sin_cos(bit [31:0] ph, output longint sn, output longint cs);
      bit [31:0] p;
      longint a, b;
      p = ph & ~((32'd1 << (32 - ANGLE_BITS_DEF)) - 32'd1);
      a = quarter_sine({34'd0, p[29:0]});
      b = quarter_sine(64'd1073741824 - {34'd0, p[29:0]});
      case (p[31:30])
        2'd0: begin sn = a;  cs = b;  end
        2'd1: begin sn = b;  cs = -a; end
        2'd2: begin sn = -a; cs = -b; end
        default: begin sn = -b; cs = a; end
      endcase
    endfunction

    function void note_input(bit [16:0] u, bit [16:0] v);
      longint pt[3], nm[3];
      longint r, s, c, ps, pc, lx, ly, acc, se, ce, cx, cy, rx, ry;
      bit [31:0] uph, eph;
      bit [95:0] res;
      r = radius;
      uph = {u[15:0], 16'd0};
      if (mode == SURF_CYLINDER) begin
        sin_cos(uph, s, c);
        sin_cos(uph + 32'h8000_0000, ps, pc);
        lx = round_shift(r * pc, 16);
        ly = round_shift(r * ps, 16);
        for (int j = 0; j < 3; j++) begin
          rx = lane(rot_x, j);
          ry = lane(rot_y, j);
          acc = lx * rx + ly * ry;
          acc += longint'(v) * lane(axis, j) * 4096;
          acc += lane(base, j) * (64'sd1 <<< 28);
          pt[j] = round_shift(acc, 28);
          nm[j] = round_shift(c * rx + s * ry, 30);
        end
      end else begin
        eph = {v, 15'd0} + 32'hC000_0000;
        sin_cos(uph, s, c);
        sin_cos(eph, se, ce);
        cx = round_shift(c * ce, 30);
        cy = round_shift(s * ce, 30);
        pt[0] = round_shift(r * cx, 30);
        pt[1] = round_shift(r * cy, 30);
        pt[2] = round_shift(r * se, 30);
        nm[0] = round_shift(cx, 16);
        nm[1] = round_shift(cy, 16);
        nm[2] = round_shift(se, 16);
      end
      for (int j = 0; j < 3; j++) begin
        if (pt[j] > 32767) pt[j] = 32767;
        if (pt[j] < -32768) pt[j] = -32768;
        if (nm[j] > 16384) nm[j] = 16384;
        if (nm[j] < -16384) nm[j] = -16384;
        res[16*j +: 16] = pt[j][15:0];
        res[48 + 16*j +: 16] = nm[j][15:0];
      end
      expected_points.insert(expected_points.size(), res);
    endfunction

    // returns empty string on match
    function string check(bit [95:0] got);
      string names[6] = '{"point_x", "point_y", "point_z", "normal_x", "normal_y", "normal_z"};
      string msg;
      bit [95:0] exp_pt;
      msg = "";
      if (expected_points.size() == 0) return "result transaction with nothing expected";
      exp_pt = expected_points.pop_front();
      for (int k = 0; k < 6; k++)
        if (got[16*k +: 16] != exp_pt[16*k +: 16])
          msg = {msg, $sformatf("%s got %0d exp %0d; ", names[k],
                 $signed(got[16*k +: 16]), $signed(exp_pt[16*k +: 16]))};
      return msg;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  surface_point_scoreboard sb = new();
  int errors = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 54;
  int hold_request = 0;

  surface_texcoord_to_world_point dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata[16:0], in_tdata[33:17]);
    if (rst_n && out_tvalid && out_tready) begin
      string m;
      m = sb.check(out_tdata);
      if (m != "") report_mismatch(m);
    end
  end

  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        held = 0;
        out_tready <= 1'b0;
        while (held < hold_request) begin
          @(posedge clk);
          held++;
        end
        hold_request = 0;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_coord(bit [16:0] u, bit [16:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, v, u};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic bit [47:0] rand48();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  function automatic bit [16:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return 17'($urandom_range(0, 131071));
    return 17'($urandom_range(0, 65536));
  endfunction

  task automatic load_setting(int k);
    write_reg(REG_MODE, {47'd0, k[0]} | {$urandom(), 16'd0} & 48'hFFFF_FFFF_FFFE);
    case (k)
      0: write_reg(REG_RADIUS, 48'd0);
      1: write_reg(REG_RADIUS, 48'hFFFF);
      default: write_reg(REG_RADIUS, rand48());
    endcase
    if (k == 1) begin
      write_reg(REG_BASE, 48'h7FFF_7FFF_7FFF);
      write_reg(REG_ROT_X, 48'h8000_8000_8000);
      write_reg(REG_ROT_Y, 48'h7FFF_7FFF_7FFF);
      write_reg(REG_AXIS, 48'h8000_8000_8000);
    end else if (k == 2) begin
      write_reg(REG_BASE, 48'h8000_8000_8000);
      write_reg(REG_ROT_X, 48'h0000_0000_4000);
      write_reg(REG_ROT_Y, 48'h0000_4000_0000);
      write_reg(REG_AXIS, 48'h7FFF_7FFF_7FFF);
    end else begin
      write_reg(REG_BASE, rand48());
      write_reg(REG_ROT_X, rand48());
      write_reg(REG_ROT_Y, rand48());
      write_reg(REG_AXIS, rand48());
    end
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7, rand48());
  endtask

  initial begin
    bit [16:0] corners[7] = '{17'd0, 17'd16384, 17'd32768, 17'd49152, 17'd65535,
                              17'd65536, 17'd131071};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int m = 0; m < 2; m++) begin
      if (m == 1) write_reg(REG_MODE, 48'd1);
      for (int i = 0; i < 7; i++) send_coord(corners[i], corners[(i * 3) % 7]);
      send_coord(17'd8192, 17'd65536);
      send_coord(17'd40000, 17'd98304);
      drain();
    end

    for (int ph = 0; ph < 8; ph++) begin
      load_setting(ph);
      if (ph < 3) begin
        send_idle_pct = 35; recv_idle_pct = 54;
      end else if (ph < 6) begin
        send_idle_pct = 54; recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int i = 0; i < 250; i++) begin
        if (ph == 6 && i == 20) hold_request = 300;
        send_coord(rand_coord(), rand_coord());
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
design/stwp_pkg.sv
design/stwp_trig.sv
design/stwp_mix.sv
design/surface_texcoord_to_world_point.sv
tb/tb_surface_texcoord_to_world_point.sv
